[rtl/core/b64_pkg.sv]
// ----------------------------------------------------------------------------
// b64_pkg: shared types, constants and alphabet helpers
// Result record, codec state and the standard Base64 alphabet mapping.
// ----------------------------------------------------------------------------
package b64_pkg;

  localparam int NumRes = 4;               // most results one request can cause
  localparam int CntW   = $clog2(NumRes + 1);

  localparam logic [7:0] PadChar = 8'h3D;  // '='

  localparam logic [0:0] DirEncode = 1'b0;
  localparam logic [0:0] DirDecode = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic       ok;    // data present, low for an empty end marker
    logic       eor;   // last result of the message
    logic       bad;   // input character outside the alphabet
  } b64_res_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] carry;
  } b64_state_t;

  // sextet to alphabet character
  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    logic [7:0] w;
    w = {2'b00, s};
    if (s < 6'd26)      sextet_char = w + 8'h41;          // 'A'
    else if (s < 6'd52) sextet_char = w - 8'd26 + 8'h61;  // 'a'
    else if (s < 6'd62) sextet_char = w - 8'd52 + 8'h30;  // '0'
    else if (s == 6'd62) sextet_char = 8'h2B;             // '+'
    else                sextet_char = 8'h2F;              // '/'
  endfunction

  // character to sextet; bit 6 flags a character outside the alphabet
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    char_sextet = 7'h40;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      char_sextet = {1'b0, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
      char_sextet = {1'b0, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
      char_sextet = {1'b0, d[5:0]};
    end else if (c == 8'h2B) begin
      char_sextet = {1'b0, 6'd62};
    end else if (c == 8'h2F) begin
      char_sextet = {1'b0, 6'd63};
    end
  endfunction

endpackage

[rtl/core/b64_step.sv]
// ----------------------------------------------------------------------------
// b64_step: single-pass codec step
// Maps one request and the current state to its results and next state.
// ----------------------------------------------------------------------------
module b64_step (
  input  logic                                   dir,
  input  b64_pkg::b64_state_t                    st,
  input  logic [7:0]                             data_in,
  input  logic                                   is_last,
  output b64_pkg::b64_res_t [b64_pkg::NumRes-1:0] res,
  output logic [b64_pkg::CntW-1:0]               cnt,
  output b64_pkg::b64_state_t                    st_nxt
);
  import b64_pkg::*;

  logic [6:0]       dec;
  logic [5:0]       v;
  logic             bad;
  b64_state_t       ns;
  logic [7:0]       chr [NumRes];
  logic             okv;
  logic [CntW-1:0]  n;

  always_comb begin
    ns  = st;
    n   = '0;
    okv = 1'b1;
    for (int i = 0; i < NumRes; i++) chr[i] = PadChar;
    dec = char_sextet(data_in);
    v   = dec[5:0];
    bad = 1'b0;

    if (dir == DirEncode) begin
      case (st.phase)
        2'd1: begin
          chr[0]   = sextet_char({2'b00, data_in[7:4]} | st.carry[5:0]);
          ns.carry = {2'b00, data_in[3:0], 2'b00};
          ns.phase = 2'd2;
          n        = CntW'(1);
        end
        2'd2: begin
          chr[0]   = sextet_char({4'h0, data_in[7:6]} | st.carry[5:0]);
          chr[1]   = sextet_char(data_in[5:0]);
          ns.carry = 8'h00;
          ns.phase = 2'd0;
          n        = CntW'(2);
        end
        default: begin
          chr[0]   = sextet_char(data_in[7:2]);
          ns.carry = {2'b00, data_in[1:0], 4'h0};
          ns.phase = 2'd1;
          n        = CntW'(1);
        end
      endcase
      if (is_last) begin
        // flush leftover bits, pad the group to four characters
        if (ns.phase == 2'd1) begin
          chr[1] = sextet_char(ns.carry[5:0]);
          n      = CntW'(4);
        end else if (ns.phase == 2'd2) begin
          chr[1] = sextet_char(ns.carry[5:0]);
          n      = CntW'(3);
        end
      end
    end else begin
      if (data_in != PadChar) begin
        if (dec[6]) begin
          v   = 6'd0;
          bad = 1'b1;
        end
        case (st.phase)
          2'd0: begin
            ns.carry = {v, 2'b00};
            ns.phase = 2'd1;
          end
          2'd1: begin
            chr[0]   = st.carry | {6'd0, v[5:4]};
            ns.carry = {v[3:0], 4'h0};
            ns.phase = 2'd2;
            n        = CntW'(1);
          end
          2'd2: begin
            chr[0]   = st.carry | {4'd0, v[5:2]};
            ns.carry = {v[1:0], 6'd0};
            ns.phase = 2'd3;
            n        = CntW'(1);
          end
          default: begin
            chr[0]   = st.carry | {2'd0, v};
            ns.carry = 8'h00;
            ns.phase = 2'd0;
            n        = CntW'(1);
          end
        endcase
      end
      // empty end marker
      if (is_last && n == '0) begin
        chr[0] = 8'h00;
        okv    = 1'b0;
        n      = CntW'(1);
      end
    end

    if (is_last) ns = '0;

    for (int i = 0; i < NumRes; i++) begin
      res[i].data = chr[i];
      res[i].ok   = (i == 0) ? okv : 1'b1;
      res[i].eor  = is_last && (n == CntW'(i + 1));
      res[i].bad  = bad;
    end
    cnt    = n;
    st_nxt = ns;
  end

endmodule

[rtl/core/b64_obuf.sv]
// ----------------------------------------------------------------------------
// b64_obuf: result buffer
// Holds the results of one request and shifts them out one per cycle while pop is high.
// ----------------------------------------------------------------------------
module b64_obuf (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   load,
  input  b64_pkg::b64_res_t [b64_pkg::NumRes-1:0] load_res,
  input  logic [b64_pkg::CntW-1:0]               load_cnt,
  input  logic                                   pop,
  output b64_pkg::b64_res_t                      head,
  output logic [b64_pkg::CntW-1:0]               cnt
);
  import b64_pkg::*;

  b64_res_t [NumRes-1:0] res_r, res_nxt;
  logic [CntW-1:0]       cnt_r, cnt_nxt;

  always_comb begin
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    if (load) begin
      res_nxt = load_res;
      cnt_nxt = load_cnt;
    end else if (pop) begin
      for (int i = 0; i < NumRes - 1; i++) res_nxt[i] = res_r[i + 1];
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign head = res_r[0];
  assign cnt  = cnt_r;

endmodule

[rtl/core/base64_codec.sv]
// ----------------------------------------------------------------------------
// base64_codec: streaming Base64 encoder / decoder, standard alphabet
// Output: first result of a request shows on the outputs in the cycle after it
//   is accepted; further results follow one per cycle while out_stall is low.
// Flow: a new request is taken once the single output port has drained the
//   result buffer, or as its last pending result leaves.
// Reset: synchronous active-low rst_n clears direction, phase, carry and the
//   buffer count; no clearing pass.
// ----------------------------------------------------------------------------
module base64_codec (
  input  logic       clk,
  input  logic       rst_n,
  // configuration: direction, 0 encode, 1 decode
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_direction,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_in,
  input  logic       in_is_last,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_out,
  output logic       out_out_valid,
  output logic       out_end_of_run,
  output logic       out_bad_char
);
  import b64_pkg::*;

  logic                  dir_r, dir_nxt;
  b64_state_t            st_r, st_nxt, st_step;
  b64_res_t [NumRes-1:0] step_res;
  logic [CntW-1:0]       step_cnt;
  b64_res_t              head;
  logic [CntW-1:0]       buf_cnt;
  logic                  pop, in_acc, cfg_acc;

  // Step logic: phase/carry and the byte or character in, all results out.
  b64_step u_step (
    .dir     (dir_r),
    .st      (st_r),
    .data_in (in_data_in),
    .is_last (in_is_last),
    .res     (step_res),
    .cnt     (step_cnt),
    .st_nxt  (st_step)
  );

  // Output side: buffer drains one result a cycle under out_stall.
  assign out_valid = (buf_cnt != '0);
  assign pop       = out_valid && !out_stall;

  // A new request is taken once the buffer empties, or in the very cycle its
  // last pending result leaves, so single-result requests stream each cycle.
  // An offered configuration write holds requests off, so the two never
  // share an edge.
  assign in_stall  = cfg_valid ||
                     !((buf_cnt == '0) || (buf_cnt == CntW'(1) && !out_stall));
  assign in_acc    = in_valid && !in_stall;

  // Configuration only while nothing is pending.
  assign cfg_ready = (buf_cnt == '0);
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_comb begin
    dir_nxt = dir_r;
    st_nxt  = st_r;
    if (cfg_acc) begin
      dir_nxt = cfg_direction;
      st_nxt  = '0;                  // direction change restarts the group
    end else if (in_acc) begin
      st_nxt  = st_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DirEncode;
      st_r  <= '0;
    end else begin
      dir_r <= dir_nxt;
      st_r  <= st_nxt;
    end
  end

  b64_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_acc && !cfg_acc),
    .load_res (step_res),
    .load_cnt (step_cnt),
    .pop      (pop),
    .head     (head),
    .cnt      (buf_cnt)
  );

  assign out_data_out   = head.data;
  assign out_out_valid  = head.ok;
  assign out_end_of_run = head.eor;
  assign out_bad_char   = head.bad;

endmodule

[rtl/core/b64_checker.sv]
// ----------------------------------------------------------------------------
// b64_checker: port-level assertions
// Watches the codec's channels and bound to the top level.
// ----------------------------------------------------------------------------
module b64_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_data_out,
  input logic       out_out_valid,
  input logic       out_end_of_run
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_out))
    else $error("stalled result changed");

  // no configuration while results are pending
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !cfg_ready)
    else $error("configuration open with results pending");

  // a configuration write never shares an edge with a request
  a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> in_stall)
    else $error("request open during configuration write");

  // an empty marker always closes the message
  a_empty_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_valid |-> out_end_of_run)
    else $error("empty marker without end of run");

  // an empty marker carries zero data
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_valid |-> out_data_out == 8'h00)
    else $error("empty marker with data");

endmodule

bind base64_codec b64_checker u_b64_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_data_out   (out_data_out),
  .out_out_valid  (out_out_valid),
  .out_end_of_run (out_end_of_run)
);

[tb/tb_base64_codec.sv]
// ----------------------------------------------------------------------------
// tb_base64_codec: self-checking testbench for the streaming Base64 codec
// A short table of directed requests, then random messages in both
// directions, each result checked field by field against a local predictor.
// ----------------------------------------------------------------------------
module tb_base64_codec;
  import b64_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_direction;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_in;
  logic       in_is_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_data_out;
  logic       out_out_valid;
  logic       out_end_of_run;
  logic       out_bad_char;

  base64_codec u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_direction  (cfg_direction),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_in     (in_data_in),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_out   (out_data_out),
    .out_out_valid  (out_out_valid),
    .out_end_of_run (out_end_of_run),
    .out_bad_char   (out_bad_char)
  );

  // directed stimulus row; 'first' is the typed first result, used when chk set
  typedef struct {
    logic [0:0] dir;
    logic [7:0] data;
    logic       last;
    bit         chk;
    b64_res_t   first;
  } stim_row_t;

  string b64_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // predictor state, mirrors direction / phase / carry of the codec
  logic [0:0] pred_dir;
  logic [1:0] pred_phase;
  logic [7:0] pred_carry;
  b64_res_t   step_res [NumRes];
  int         step_n;

  b64_res_t   pending_res [$];   // results still owed by the codec
  stim_row_t  dir_rows [$];

  int  n_err, n_req, n_enc, n_dec, n_res, n_flagged, n_empty, n_cfg;
  bit  tx_idle_on, rx_idle_on;
  bit  hold_req;

  // ---------------------------------------------------------------- clocking
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard limit on the whole run
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [7:0] alpha_of(input logic [5:0] s);
    return b64_alphabet[s];
  endfunction

  // bit 6 set: character outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    for (int i = 0; i < 64; i++)
      if (b64_alphabet[i] == c) return {1'b0, 6'(i)};
    return 7'h40;
  endfunction

  function automatic void put(input logic [7:0] d, input logic ok, input logic bad);
    step_res[step_n] = {d, ok, 1'b0, bad};
    step_n++;
  endfunction

  // works out the results one request causes, into step_res[0 .. step_n-1]
  function automatic void b64_predict(input logic [7:0] d, input logic last);
    logic [7:0] t;
    logic [6:0] lk;
    logic [5:0] v;
    logic       bad;
    step_n = 0;
    bad    = 1'b0;
    if (pred_dir == DirEncode) begin
      case (pred_phase)
        2'd1: begin
          t = {4'h0, d[7:4]} | pred_carry;
          put(alpha_of(t[5:0]), 1'b1, 1'b0);
          pred_carry = {2'b00, d[3:0], 2'b00};
          pred_phase = 2'd2;
        end
        2'd2: begin
          t = {6'h00, d[7:6]} | pred_carry;
          put(alpha_of(t[5:0]), 1'b1, 1'b0);
          put(alpha_of(d[5:0]), 1'b1, 1'b0);
          pred_carry = 8'h00;
          pred_phase = 2'd0;
        end
        default: begin   // phase three cannot occur in encode; treated as zero
          put(alpha_of(d[7:2]), 1'b1, 1'b0);
          pred_carry = {2'b00, d[1:0], 4'h0};
          pred_phase = 2'd1;
        end
      endcase
      // flush leftover sextet and pad the group out to four characters
      if (last && pred_phase == 2'd1) begin
        put(alpha_of(pred_carry[5:0]), 1'b1, 1'b0);
        put(PadChar, 1'b1, 1'b0);
        put(PadChar, 1'b1, 1'b0);
      end else if (last && pred_phase == 2'd2) begin
        put(alpha_of(pred_carry[5:0]), 1'b1, 1'b0);
        put(PadChar, 1'b1, 1'b0);
      end
    end else begin
      // padding leaves the group untouched
      if (d != PadChar) begin
        lk  = sextet_of(d);
        bad = lk[6];
        v   = bad ? 6'd0 : lk[5:0];
        case (pred_phase)
          2'd0: begin
            pred_carry = {v, 2'b00};
            pred_phase = 2'd1;
          end
          2'd1: begin
            put(pred_carry | {6'h00, v[5:4]}, 1'b1, bad);
            pred_carry = {v[3:0], 4'h0};
            pred_phase = 2'd2;
          end
          2'd2: begin
            put(pred_carry | {4'h0, v[5:2]}, 1'b1, bad);
            pred_carry = {v[1:0], 6'h00};
            pred_phase = 2'd3;
          end
          default: begin
            put(pred_carry | {2'b00, v}, 1'b1, bad);
            pred_carry = 8'h00;
            pred_phase = 2'd0;
          end
        endcase
      end
      // empty end marker still carries the flag of this character
      if (last && step_n == 0) put(8'h00, 1'b0, bad);
    end
    if (last) begin
      step_res[step_n-1].eor = 1'b1;
      pred_phase = 2'd0;
      pred_carry = 8'h00;
    end
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_miss(input string what, input b64_res_t want, input b64_res_t got);
    n_err++;
    if (n_err <= 10)
      $display("%s: want data=%02h ok=%0b eor=%0b bad=%0b, got data=%02h ok=%0b eor=%0b bad=%0b",
               what, want.data, want.ok, want.eor, want.bad,
               got.data, got.ok, got.eor, got.bad);
  endtask

  always @(posedge clk) begin : res_check
    b64_res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_data_out, out_out_valid, out_end_of_run, out_bad_char};
      n_res++;
      if (got.bad) n_flagged++;
      if (!got.ok) n_empty++;
      if (pending_res.size() == 0) begin
        report_miss("unexpected result", '0, got);
      end else begin
        if (got !== pending_res[0]) report_miss("result mismatch", pending_res[0], got);
        void'(pending_res.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  // random stalls, plus one long hold-off on request from the main sequence
  initial begin : rx_side
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (64) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(99) < 28) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- sender
  // called at a rising edge; returns at the edge where the request went in
  task automatic send_req(input logic [7:0] d, input logic last);
    if (tx_idle_on && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data_in <= d;
    in_is_last <= last;
    do @(posedge clk); while (in_stall);
    if (pred_dir == DirEncode) n_enc++;
    else n_dec++;
    n_req++;
    b64_predict(d, last);
    for (int i = 0; i < step_n; i++) pending_res.push_back(step_res[i]);
  endtask

  // direction written only once the codec has drained
  task automatic write_direction(input logic [0:0] d);
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    // a request with no result may still be in flight
    repeat (6) @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_direction <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    pred_dir   = d;
    pred_phase = 2'd0;
    pred_carry = 8'h00;
    n_cfg++;
  endtask

  function automatic void add_row(input logic [0:0] dir, input logic [7:0] data,
                                  input logic last, input int chk,
                                  input logic [7:0] fd, input int fok,
                                  input int feor, input int fbad);
    stim_row_t r;
    r.dir   = dir;
    r.data  = data;
    r.last  = last;
    r.chk   = (chk != 0);
    r.first = {fd, fok[0], feor[0], fbad[0]};
    dir_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------- main
  initial begin : main_seq
    int         left, len, padn, r;
    bit         term;
    logic [7:0] c;
    logic [0:0] dir;

    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_direction = 1'b0;
    in_valid      = 1'b0;
    in_data_in    = 8'h00;
    in_is_last    = 1'b0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    hold_req      = 1'b0;
    pred_dir      = DirEncode;
    pred_phase    = 2'd0;
    pred_carry    = 8'h00;

    // encode straight out of reset: extremes of the byte, flush with one
    // and two pads, the textbook three-byte group
    add_row(DirEncode, 8'h00, 1'b0, 1, 8'h41, 1, 0, 0);   // 'A'
    add_row(DirEncode, 8'hFF, 1'b0, 1, 8'h50, 1, 0, 0);   // 'P'
    add_row(DirEncode, 8'hFF, 1'b1, 1, 8'h2F, 1, 0, 0);   // '/', '/' ends
    add_row(DirEncode, 8'hFF, 1'b1, 1, 8'h2F, 1, 0, 0);   // four results: "/w=="
    add_row(DirEncode, 8'h00, 1'b1, 1, 8'h41, 1, 0, 0);   // "AA=="
    add_row(DirEncode, 8'h4D, 1'b0, 0, '0, 0, 0, 0);
    add_row(DirEncode, 8'h61, 1'b1, 0, '0, 0, 0, 0);      // one pad
    add_row(DirEncode, 8'h4D, 1'b0, 0, '0, 0, 0, 0);
    add_row(DirEncode, 8'h61, 1'b0, 0, '0, 0, 0, 0);
    add_row(DirEncode, 8'h6E, 1'b1, 0, '0, 0, 0, 0);      // full group, no pad
    // decode: a clean group, empty end, invalid characters, padding
    add_row(DirDecode, 8'h54, 1'b0, 0, '0, 0, 0, 0);      // 'T'
    add_row(DirDecode, 8'h57, 1'b0, 1, 8'h4D, 1, 0, 0);   // 'W'
    add_row(DirDecode, 8'h46, 1'b0, 1, 8'h61, 1, 0, 0);   // 'F'
    add_row(DirDecode, 8'h75, 1'b1, 1, 8'h6E, 1, 1, 0);   // 'u'
    add_row(DirDecode, PadChar, 1'b1, 1, 8'h00, 0, 1, 0); // empty end marker
    add_row(DirDecode, 8'h2A, 1'b1, 1, 8'h00, 0, 1, 1);   // '*' alone, flagged
    add_row(DirDecode, 8'h2F, 1'b0, 0, '0, 0, 0, 0);      // '/'
    add_row(DirDecode, 8'hFF, 1'b0, 1, 8'hFC, 1, 0, 1);   // invalid as zero
    add_row(DirDecode, 8'h80, 1'b0, 1, 8'h00, 1, 0, 1);
    add_row(DirDecode, 8'h00, 1'b1, 1, 8'h00, 1, 1, 1);
    add_row(DirDecode, 8'h51, 1'b0, 0, '0, 0, 0, 0);      // 'Q'
    add_row(DirDecode, 8'h51, 1'b0, 1, 8'h41, 1, 0, 0);
    add_row(DirDecode, PadChar, 1'b0, 0, '0, 0, 0, 0);    // pad, no result
    add_row(DirDecode, PadChar, 1'b1, 1, 8'h00, 0, 1, 0);
    add_row(DirDecode, 8'h2B, 1'b1, 1, 8'h00, 0, 1, 0);   // '+' alone

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].dir != pred_dir) write_direction(dir_rows[i].dir);
      send_req(dir_rows[i].data, dir_rows[i].last);
      if (dir_rows[i].chk && (step_n == 0 || step_res[0] !== dir_rows[i].first))
        report_miss("directed row", dir_rows[i].first, step_res[0]);
    end

    // random phases, direction alternating; each begins with a write
    for (int p = 0; p < 8; p++) begin
      dir = p[0] ? DirDecode : DirEncode;
      write_direction(dir);
      tx_idle_on = !(p == 2 || p == 3);   // long stretch at full rate
      rx_idle_on = tx_idle_on;
      if (p == 4) hold_req = 1'b1;        // receiver backs off, input fills up
      left = 13;
      while (left > 0) begin
        if (dir == DirEncode) begin
          len  = $urandom_range(1, 7);
          padn = 0;
        end else if ($urandom_range(99) < 15) begin
          len  = $urandom_range(1, 9);     // broken group length
          padn = 0;
        end else begin
          len  = 4 * $urandom_range(1, 2);
          padn = $urandom_range(0, 2);
        end
        // a message cut short by the phase end is left open
        term = 1;
        if (len > left) begin
          len  = left;
          term = 0;
          padn = 0;
        end
        left -= len;
        for (int k = 0; k < len; k++) begin
          if (dir == DirEncode) begin
            c = 8'($urandom_range(255));
          end else if (k >= len - padn) begin
            c = PadChar;
          end else begin
            r = $urandom_range(99);
            if (r < 8) c = 8'($urandom_range(255));
            else if (r < 11) c = PadChar;
            else c = b64_alphabet[$urandom_range(63)];
          end
          send_req(c, term && (k == len - 1));
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d requests (%0d encode, %0d decode), %0d results checked",
             n_req, n_enc, n_dec, n_res);
    $display("  %0d flagged characters, %0d empty end markers, %0d direction writes",
             n_flagged, n_empty, n_cfg);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", n_err);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
